// ===== hw/rtl/bsse_pkg.sv =====
// Shared constants, codes and fixed-point helpers for the B-spline surface evaluator.
// Used by the top level; no dependencies.
`default_nettype none
package bsse_pkg;

  localparam int DEF_MAX_ROWS   = 16;
  localparam int DEF_MAX_COLS   = 16;
  localparam int DEF_MAX_DEGREE = 7;
  localparam int DEF_KNOT_DEPTH = 32;

  localparam logic [1:0] FN_POINT = 2'd0;
  localparam logic [1:0] FN_UKNOT = 2'd1;
  localparam logic [1:0] FN_VKNOT = 2'd2;
  localparam logic [1:0] FN_EVAL  = 2'd3;

  localparam logic [1:0] KIND_DU = 2'd1;
  localparam logic [1:0] KIND_DV = 2'd2;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_SAT   = 2'd2;

  localparam logic [1:0] CFG_UDEG = 2'd0;
  localparam logic [1:0] CFG_VDEG = 2'd1;
  localparam logic [1:0] CFG_UCNT = 2'd2;
  localparam logic [1:0] CFG_VCNT = 2'd3;

  localparam logic signed [17:0] Q16_ONE   = 18'sd65536;
  localparam logic signed [63:0] Q30_ONE   = 64'sh0000_0000_4000_0000;
  localparam logic signed [63:0] BASIS_LIM = 64'sh0000_0100_0000_0000;
  localparam logic signed [63:0] DERIV_LIM = 64'sh0100_0000_0000_0000;
  localparam logic signed [63:0] S64_MAX   = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] S64_MIN   = 64'sh8000_0000_0000_0000;
  localparam logic signed [63:0] S32_MAX   = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] S32_MIN   = 64'shFFFF_FFFF_8000_0000;

  // Magnitude product shifted right by 30 with sign applied, saturated to 64 bits.
  function automatic logic signed [63:0] q30(input logic [127:0] mag, input logic neg);
    logic signed [63:0] v;
    v = $signed({1'b0, mag[92:30]});
    if (|mag[127:93]) begin
      return neg ? S64_MIN : S64_MAX;
    end
    return neg ? -v : v;
  endfunction

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s[64] != s[63]) begin
      return s[64] ? S64_MIN : S64_MAX;
    end
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] clamp_s(input logic signed [63:0] v,
                                                 input logic signed [63:0] lim);
    if (v > lim) begin
      return lim;
    end
    if (v < -lim) begin
      return -lim;
    end
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/bsse_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module bsse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ===== hw/rtl/bsse_mul.sv =====
// Iterative signed 64 by 64 multiplier: one 32 by 32 partial product per cycle.
// Gives the 128-bit magnitude of the product and its sign. No dependencies.
`default_nettype none
module bsse_mul (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic signed [63:0] a_i,
  input  wire logic signed [63:0] b_i,
  output logic                    done_o,
  output logic [127:0]            prod_o,
  output logic                    neg_o
);

  logic [63:0]  am_q, bm_q;
  logic [127:0] acc_q;
  logic [1:0]   step_q;
  logic         run_q, done_q, neg_q;
  logic [63:0]  pp;
  logic [127:0] pp_sh;

  always_comb begin
    pp = 64'(step_q[0] ? am_q[63:32] : am_q[31:0]) * 64'(step_q[1] ? bm_q[63:32] : bm_q[31:0]);
    case (step_q)
      2'd0:    pp_sh = {64'd0, pp};
      2'd3:    pp_sh = {pp, 64'd0};
      default: pp_sh = {32'd0, pp, 32'd0};
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      step_q <= 2'd0;
      am_q   <= 64'd0;
      bm_q   <= 64'd0;
      acc_q  <= 128'd0;
      neg_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        am_q   <= a_i[63] ? 64'(-a_i) : 64'(a_i);
        bm_q   <= b_i[63] ? 64'(-b_i) : 64'(b_i);
        neg_q  <= a_i[63] ^ b_i[63];
        acc_q  <= 128'd0;
        step_q <= 2'd0;
        run_q  <= 1'b1;
      end else if (run_q) begin
        acc_q  <= acc_q + pp_sh;
        step_q <= step_q + 2'd1;
        if (step_q == 2'd3) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;
  assign neg_o  = neg_q;

endmodule
`default_nettype wire

// ===== hw/rtl/bsse_div.sv =====
// Bit-serial restoring divider: 64-bit magnitude by 18-bit magnitude, one quotient bit per cycle.
// The quotient is truncated toward zero and carries the given sign. No dependencies.
`default_nettype none
module bsse_div (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic [63:0]        num_i,
  input  wire logic [17:0]        den_i,
  input  wire logic               neg_i,
  output logic                    done_o,
  output logic signed [63:0]      quo_o
);

  logic [63:0] num_q;
  logic [17:0] rem_q, den_q;
  logic [5:0]  cnt_q;
  logic        run_q, done_q, neg_q;
  logic [18:0] trial, diff;
  logic        qbit;

  always_comb begin
    trial = {rem_q, num_q[63]};
    diff  = trial - {1'b0, den_q};
    qbit  = (trial >= {1'b0, den_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 6'd0;
      num_q  <= 64'd0;
      rem_q  <= 18'd0;
      den_q  <= 18'd0;
      neg_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        num_q <= num_i;
        den_q <= den_i;
        neg_q <= neg_i;
        rem_q <= 18'd0;
        cnt_q <= 6'd0;
        run_q <= 1'b1;
      end else if (run_q) begin
        rem_q <= qbit ? diff[17:0] : trial[17:0];
        num_q <= {num_q[62:0], qbit};
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = neg_q ? -$signed(num_q) : $signed(num_q);

endmodule
`default_nettype wire

// ===== hw/rtl/bspline_surface_evaluator_top.sv =====
// Top level of the B-spline surface evaluator: sequencer, basis and weight registers, stores.
// Depends on bsse_pkg, bsse_ram, bsse_mul and bsse_div.
//
// Load items (control point, u knot, v knot) are written on acceptance and their result
// strobes on the next cycle; an evaluation with a parameter outside 0 to 1 also answers on the
// next cycle. An evaluation keeps busy high for its whole run. Each basis term uses up to two
// 64-step serial divisions and up to two 4-step multiplies (three in a derivative pass); there
// are p(p+3)/2 terms per direction plus p+1 more for a derivative direction, then each of the
// (pu+1)(pv+1) control points is weighted with two multiplies per coordinate on the shared
// multiplier. Each result is a single-cycle transfer on done_o.
`default_nettype none
module bspline_surface_evaluator_top
  import bsse_pkg::*;
#(
  parameter int MAX_ROWS   = DEF_MAX_ROWS,
  parameter int MAX_COLS   = DEF_MAX_COLS,
  parameter int MAX_DEGREE = DEF_MAX_DEGREE,
  parameter int KNOT_DEPTH = DEF_KNOT_DEPTH
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         func_i,
  input  wire logic [3:0]         grid_row_i,
  input  wire logic [3:0]         grid_col_i,
  input  wire logic [4:0]         knot_slot_i,
  input  wire logic [16:0]        knot_value_i,
  input  wire logic signed [31:0] coord_x_i,
  input  wire logic signed [31:0] coord_y_i,
  input  wire logic signed [31:0] coord_z_i,
  input  wire logic signed [17:0] u_param_i,
  input  wire logic signed [17:0] v_param_i,
  input  wire logic [1:0]         result_kind_i,
  output logic                    done_o,
  output logic [1:0]              status_o,
  output logic signed [31:0]      out_x_o,
  output logic signed [31:0]      out_y_o,
  output logic signed [31:0]      out_z_o,
  input  wire logic               cfg_we_i,
  input  wire logic [1:0]         cfg_idx_i,
  input  wire logic [4:0]         cfg_data_i
);

  localparam int MAXN = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
  localparam int NW   = $clog2(MAXN + 1);
  localparam int PW   = $clog2(MAX_DEGREE + 1);
  localparam int RW   = $clog2(MAX_DEGREE + 2);
  localparam int KIW  = $clog2(MAXN + MAX_DEGREE + 1);
  localparam int KAW  = $clog2(KNOT_DEPTH);
  localparam int CAW  = $clog2(MAX_ROWS * MAX_COLS);
  localparam int NBW  = 42;
  localparam int WTW  = 58;
  localparam int QW   = 60;

  typedef enum logic [4:0] {
    S_IDLE, S_SETUP, S_SPAN_RD, S_SPAN_CMP, S_LVL, S_FETCH, S_TERM, S_MUL_W, S_DIV_W,
    S_COMB, S_PMUL_W, S_NEXT, S_ACC_RD, S_ACC_CAP, S_ACC_M1, S_ACC_M1W, S_ACC_M2W, S_FIN
  } state_e;

  state_e state_q;

  logic [2:0] u_deg_q, v_deg_q;
  logic [4:0] u_cnt_q, v_cnt_q;

  logic [16:0] tu_q, tv_q, cur_t_q;
  logic [1:0]  kind_q;
  logic        dir_q, deriv_q, h_q;
  logic [PW-1:0] cur_p_q, j_q, a_q, b_q;
  logic [NW-1:0] cur_n_q, span_q, i_q, su_q, sv_q;
  logic [RW-1:0] r_q;
  logic [2:0]    f_q;
  logic [1:0]    c_q;
  logic [16:0]   kreg_q [4];
  logic signed [QW-1:0]  part_q [2];
  logic signed [NBW-1:0] nb_q [MAX_DEGREE+2];
  logic signed [NBW-1:0] prev_q [MAX_DEGREE+2];
  logic signed [WTW-1:0] wtu_q [MAX_DEGREE+1];
  logic signed [WTW-1:0] wtv_q [MAX_DEGREE+1];
  logic signed [63:0]    acc_q [3];
  logic [95:0]           cp_q;

  logic              done_q;
  logic [1:0]        status_q;
  logic signed [31:0] ox_q, oy_q, oz_q;

  function automatic logic [NW-1:0] eff_cnt(input logic [4:0] c, input int maxc);
    if (int'(c) < 2) begin
      return NW'(2);
    end
    if (int'(c) > maxc) begin
      return NW'(maxc);
    end
    return NW'(c);
  endfunction

  function automatic logic [PW-1:0] eff_deg(input logic [2:0] d, input logic [NW-1:0] n);
    int dd;
    dd = int'(d);
    if (dd < 1) begin
      dd = 1;
    end
    if (dd > MAX_DEGREE) begin
      dd = MAX_DEGREE;
    end
    if (dd > int'(n) - 1) begin
      dd = int'(n) - 1;
    end
    return PW'(dd);
  endfunction

  logic [NW-1:0] nr_c, nc_c;
  logic [PW-1:0] pu_c, pv_c;
  logic          accept, need_deriv;

  assign nr_c = eff_cnt(u_cnt_q, MAX_ROWS);
  assign nc_c = eff_cnt(v_cnt_q, MAX_COLS);
  assign pu_c = eff_deg(u_deg_q, nr_c);
  assign pv_c = eff_deg(v_deg_q, nc_c);
  assign accept = start && !busy;
  assign need_deriv = dir_q ? (kind_q == KIND_DV) : (kind_q == KIND_DU);

  // Knot store addressing
  logic [KIW-1:0] k_c, koff, kidx;
  logic [KAW-1:0] knot_raddr;
  logic [16:0]    uk_rdata, vk_rdata, kdata;

  always_comb begin
    k_c = KIW'(span_q) - KIW'(cur_p_q) + KIW'(r_q);
    case (f_q)
      3'd1:    koff = KIW'(j_q);
      3'd2:    koff = KIW'(1);
      3'd3:    koff = KIW'(j_q) + KIW'(1);
      default: koff = '0;
    endcase
    kidx = (state_q == S_SPAN_RD) ? KIW'(i_q) : k_c + koff;
    knot_raddr = (int'(kidx) >= KNOT_DEPTH) ? KAW'(KNOT_DEPTH - 1) : KAW'(kidx);
    kdata = dir_q ? vk_rdata : uk_rdata;
  end

  logic knot_slot_ok;
  assign knot_slot_ok = int'(knot_slot_i) < KNOT_DEPTH;

  bsse_ram #(.WIDTH(17), .DEPTH(KNOT_DEPTH)) u_uknots (
    .clk_i   (clk_i),
    .we_i    (accept && func_i == FN_UKNOT && knot_slot_ok),
    .waddr_i (KAW'(knot_slot_i)),
    .wdata_i (knot_value_i),
    .raddr_i (knot_raddr),
    .rdata_o (uk_rdata)
  );

  bsse_ram #(.WIDTH(17), .DEPTH(KNOT_DEPTH)) u_vknots (
    .clk_i   (clk_i),
    .we_i    (accept && func_i == FN_VKNOT && knot_slot_ok),
    .waddr_i (KAW'(knot_slot_i)),
    .wdata_i (knot_value_i),
    .raddr_i (knot_raddr),
    .rdata_o (vk_rdata)
  );

  // Control point store
  logic [CAW-1:0] cp_waddr, cp_raddr;
  logic [NW-1:0]  gr, gc;
  logic [95:0]    cp_rdata;
  logic           cp_we;

  always_comb begin
    gr = su_q - NW'(pu_c) + NW'(a_q);
    gc = sv_q - NW'(pv_c) + NW'(b_q);
    cp_raddr = CAW'(gr) * CAW'(MAX_COLS) + CAW'(gc);
    cp_waddr = CAW'(grid_row_i) * CAW'(MAX_COLS) + CAW'(grid_col_i);
    cp_we = accept && func_i == FN_POINT &&
            int'(grid_row_i) < MAX_ROWS && int'(grid_col_i) < MAX_COLS;
  end

  bsse_ram #(.WIDTH(96), .DEPTH(MAX_ROWS * MAX_COLS)) u_points (
    .clk_i   (clk_i),
    .we_i    (cp_we),
    .waddr_i (cp_waddr),
    .wdata_i ({coord_z_i, coord_y_i, coord_x_i}),
    .raddr_i (cp_raddr),
    .rdata_o (cp_rdata)
  );

  // Shared arithmetic units
  logic               mul_start, mul_done, mul_neg;
  logic signed [63:0] mul_a, mul_b;
  logic [127:0]       mul_prod;
  logic               div_start, div_done;
  logic signed [63:0] div_quo;

  logic signed [17:0] kd, kdmag, fa;
  logic [RW-1:0]      ridx;
  logic signed [63:0] sum_c, mq30, cp_coord;

  always_comb begin
    kd = h_q ? ($signed({1'b0, kreg_q[3]}) - $signed({1'b0, kreg_q[2]}))
             : ($signed({1'b0, kreg_q[1]}) - $signed({1'b0, kreg_q[0]}));
    kdmag = kd[17] ? -kd : kd;
    if (deriv_q) begin
      fa = h_q ? -Q16_ONE : Q16_ONE;
    end else begin
      fa = h_q ? ($signed({1'b0, kreg_q[3]}) - $signed({1'b0, cur_t_q}))
               : ($signed({1'b0, cur_t_q}) - $signed({1'b0, kreg_q[0]}));
    end
    ridx = r_q + RW'(h_q);
    sum_c = 64'(part_q[0]) + 64'(part_q[1]);
    mq30 = q30(mul_prod, mul_neg);
    case (c_q)
      2'd1:    cp_coord = 64'($signed(cp_q[63:32]));
      2'd2:    cp_coord = 64'($signed(cp_q[95:64]));
      default: cp_coord = 64'($signed(cp_q[31:0]));
    endcase
    mul_start = 1'b0;
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_TERM: begin
        mul_start = (kd != 18'sd0);
        mul_a = 64'(fa);
        mul_b = deriv_q ? 64'(prev_q[ridx]) : 64'(nb_q[ridx]);
      end
      S_COMB: begin
        mul_start = deriv_q;
        mul_a = $signed(64'(cur_p_q));
        mul_b = sum_c;
      end
      S_ACC_M1: begin
        mul_start = 1'b1;
        mul_a = cp_coord;
        mul_b = 64'(wtu_q[a_q]);
      end
      S_ACC_M1W: begin
        mul_start = mul_done;
        mul_a = mq30;
        mul_b = 64'(wtv_q[b_q]);
      end
      default: begin
        mul_start = 1'b0;
      end
    endcase
    div_start = (state_q == S_MUL_W) && mul_done;
  end

  bsse_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_prod),
    .neg_o   (mul_neg)
  );

  bsse_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (mul_prod[63:0]),
    .den_i   (kdmag),
    .neg_i   (mul_neg ^ kd[17]),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  logic signed [63:0] basis_v, deriv_v, term_v, pmul_v;
  logic [PW-1:0]      rw;

  always_comb begin
    basis_v = clamp_s(sum_c, BASIS_LIM);
    pmul_v  = mul_neg ? -$signed(mul_prod[63:0]) : $signed(mul_prod[63:0]);
    deriv_v = clamp_s(pmul_v, DERIV_LIM);
    term_v  = sat_add(acc_q[c_q], mq30);
    rw      = r_q[PW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      u_deg_q  <= 3'd3;
      v_deg_q  <= 3'd3;
      u_cnt_q  <= 5'd4;
      v_cnt_q  <= 5'd4;
      done_q   <= 1'b0;
      status_q <= ST_DONE;
      ox_q     <= '0;
      oy_q     <= '0;
      oz_q     <= '0;
      tu_q     <= '0;
      tv_q     <= '0;
      cur_t_q  <= '0;
      kind_q   <= '0;
      dir_q    <= 1'b0;
      deriv_q  <= 1'b0;
      h_q      <= 1'b0;
      cur_p_q  <= '0;
      j_q      <= '0;
      a_q      <= '0;
      b_q      <= '0;
      cur_n_q  <= '0;
      span_q   <= '0;
      i_q      <= '0;
      su_q     <= '0;
      sv_q     <= '0;
      r_q      <= '0;
      f_q      <= '0;
      c_q      <= '0;
      cp_q     <= '0;
      for (int n = 0; n < 4; n++) kreg_q[n] <= '0;
      for (int n = 0; n < 2; n++) part_q[n] <= '0;
      for (int n = 0; n < 3; n++) acc_q[n] <= '0;
      for (int n = 0; n < MAX_DEGREE + 2; n++) begin
        nb_q[n]   <= '0;
        prev_q[n] <= '0;
      end
      for (int n = 0; n < MAX_DEGREE + 1; n++) begin
        wtu_q[n] <= '0;
        wtv_q[n] <= '0;
      end
    end else begin
      done_q <= 1'b0;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_UDEG: u_deg_q <= cfg_data_i[2:0];
          CFG_VDEG: v_deg_q <= cfg_data_i[2:0];
          CFG_UCNT: u_cnt_q <= cfg_data_i;
          CFG_VCNT: v_cnt_q <= cfg_data_i;
          default:  u_deg_q <= u_deg_q;
        endcase
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            ox_q <= '0;
            oy_q <= '0;
            oz_q <= '0;
            if (func_i != FN_EVAL) begin
              done_q   <= 1'b1;
              status_q <= ST_DONE;
            end else if (u_param_i < 0 || u_param_i > Q16_ONE ||
                         v_param_i < 0 || v_param_i > Q16_ONE) begin
              done_q   <= 1'b1;
              status_q <= ST_RANGE;
            end else begin
              tu_q    <= u_param_i[16:0];
              tv_q    <= v_param_i[16:0];
              kind_q  <= result_kind_i;
              dir_q   <= 1'b0;
              for (int n = 0; n < 3; n++) acc_q[n] <= '0;
              state_q <= S_SETUP;
            end
          end
        end
        S_SETUP: begin
          cur_p_q <= dir_q ? pv_c : pu_c;
          cur_n_q <= dir_q ? nc_c : nr_c;
          cur_t_q <= dir_q ? tv_q : tu_q;
          i_q     <= NW'(dir_q ? pv_c : pu_c);
          span_q  <= NW'(dir_q ? pv_c : pu_c);
          deriv_q <= 1'b0;
          state_q <= S_SPAN_RD;
        end
        S_SPAN_RD: begin
          state_q <= S_SPAN_CMP;
        end
        S_SPAN_CMP: begin
          if (kdata <= cur_t_q) begin
            span_q <= i_q;
          end
          i_q <= i_q + NW'(1);
          if (i_q + NW'(1) == cur_n_q) begin
            for (int n = 0; n < MAX_DEGREE + 2; n++) nb_q[n] <= '0;
            nb_q[RW'(cur_p_q)] <= NBW'(Q30_ONE);
            j_q     <= PW'(1);
            state_q <= S_LVL;
          end else begin
            state_q <= S_SPAN_RD;
          end
        end
        S_LVL: begin
          if (j_q == cur_p_q) begin
            for (int n = 0; n < MAX_DEGREE + 2; n++) prev_q[n] <= nb_q[n];
          end
          r_q     <= RW'(cur_p_q - j_q);
          f_q     <= '0;
          h_q     <= 1'b0;
          state_q <= S_FETCH;
        end
        S_FETCH: begin
          if (f_q != 3'd0) begin
            kreg_q[2'(f_q - 3'd1)] <= kdata;
          end
          if (f_q == 3'd4) begin
            state_q <= S_TERM;
          end else begin
            f_q <= f_q + 3'd1;
          end
        end
        S_TERM: begin
          if (kd == 18'sd0) begin
            part_q[h_q] <= '0;
            if (h_q) begin
              state_q <= S_COMB;
            end else begin
              h_q <= 1'b1;
            end
          end else begin
            state_q <= S_MUL_W;
          end
        end
        S_MUL_W: begin
          if (mul_done) begin
            state_q <= S_DIV_W;
          end
        end
        S_DIV_W: begin
          if (div_done) begin
            part_q[h_q] <= div_quo[QW-1:0];
            if (h_q) begin
              state_q <= S_COMB;
            end else begin
              h_q     <= 1'b1;
              state_q <= S_TERM;
            end
          end
        end
        S_COMB: begin
          if (deriv_q) begin
            state_q <= S_PMUL_W;
          end else begin
            nb_q[r_q] <= basis_v[NBW-1:0];
            if (j_q == cur_p_q && !need_deriv) begin
              if (dir_q) begin
                wtv_q[rw] <= WTW'(basis_v);
              end else begin
                wtu_q[rw] <= WTW'(basis_v);
              end
            end
            state_q <= S_NEXT;
          end
        end
        S_PMUL_W: begin
          if (mul_done) begin
            if (dir_q) begin
              wtv_q[rw] <= deriv_v[WTW-1:0];
            end else begin
              wtu_q[rw] <= deriv_v[WTW-1:0];
            end
            state_q <= S_NEXT;
          end
        end
        S_NEXT: begin
          f_q <= '0;
          h_q <= 1'b0;
          if (r_q == RW'(cur_p_q)) begin
            if (!deriv_q && j_q != cur_p_q) begin
              j_q     <= j_q + PW'(1);
              state_q <= S_LVL;
            end else if (!deriv_q && need_deriv) begin
              deriv_q <= 1'b1;
              r_q     <= '0;
              state_q <= S_FETCH;
            end else if (!dir_q) begin
              su_q    <= span_q;
              dir_q   <= 1'b1;
              state_q <= S_SETUP;
            end else begin
              sv_q    <= span_q;
              a_q     <= '0;
              b_q     <= '0;
              state_q <= S_ACC_RD;
            end
          end else begin
            r_q     <= r_q + RW'(1);
            state_q <= S_FETCH;
          end
        end
        S_ACC_RD: begin
          state_q <= S_ACC_CAP;
        end
        S_ACC_CAP: begin
          cp_q    <= cp_rdata;
          c_q     <= 2'd0;
          state_q <= S_ACC_M1;
        end
        S_ACC_M1: begin
          state_q <= S_ACC_M1W;
        end
        S_ACC_M1W: begin
          if (mul_done) begin
            state_q <= S_ACC_M2W;
          end
        end
        S_ACC_M2W: begin
          if (mul_done) begin
            acc_q[c_q] <= term_v;
            if (c_q != 2'd2) begin
              c_q     <= c_q + 2'd1;
              state_q <= S_ACC_M1;
            end else if (b_q != pv_c) begin
              b_q     <= b_q + PW'(1);
              state_q <= S_ACC_RD;
            end else if (a_q != pu_c) begin
              a_q     <= a_q + PW'(1);
              b_q     <= '0;
              state_q <= S_ACC_RD;
            end else begin
              state_q <= S_FIN;
            end
          end
        end
        S_FIN: begin
          ox_q     <= clamp32(acc_q[0]);
          oy_q     <= clamp32(acc_q[1]);
          oz_q     <= clamp32(acc_q[2]);
          status_q <= (out32(acc_q[0]) || out32(acc_q[1]) || out32(acc_q[2])) ? ST_SAT
                                                                            : ST_DONE;
          done_q   <= 1'b1;
          state_q  <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  function automatic logic out32(input logic signed [63:0] v);
    return (v > S32_MAX) || (v < S32_MIN);
  endfunction

  function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
    if (v > S32_MAX) begin
      return 32'sh7FFF_FFFF;
    end
    if (v < S32_MIN) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  assign busy     = (state_q != S_IDLE);
  assign done_o   = done_q;
  assign status_o = status_q;
  assign out_x_o  = ox_q;
  assign out_y_o  = oy_q;
  assign out_z_o  = oz_q;

endmodule
`default_nettype wire

// ===== sim/bspline_surface_evaluator_top_test.sv =====
// Self-checking testbench for the B-spline surface evaluator: loads grids and knot vectors,
// evaluates points and partial derivatives, and predicts every result in a scoreboard class.
// Depends on bsse_pkg and the bspline_surface_evaluator_top RTL.
`default_nettype none
module bspline_surface_evaluator_top_test;
  import bsse_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [1:0]         func;
    logic [3:0]         row;
    logic [3:0]         col;
    logic [4:0]         slot;
    logic [16:0]        kval;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] cz;
    logic signed [17:0] tu;
    logic signed [17:0] tv;
    logic [1:0]         kind;
  } surf_item_t;

  typedef struct {
    logic [1:0]         status;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } surf_result_t;

  class surface_scoreboard;
    longint       grid [256][3];
    longint       uknot [32];
    longint       vknot [32];
    int unsigned  udeg, vdeg, ucnt, vcnt;
    surf_result_t pending [$];
    int           errors;

    function new();
      foreach (grid[i, c]) grid[i][c] = 0;
      foreach (uknot[i]) begin
        uknot[i] = 0;
        vknot[i] = 0;
      end
      udeg = 3; vdeg = 3; ucnt = 4; vcnt = 4;
      errors = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [4:0] d);
      case (idx)
        CFG_UDEG: udeg = d & 5'd7;
        CFG_VDEG: vdeg = d & 5'd7;
        CFG_UCNT: ucnt = d;
        default:  vcnt = d;
      endcase
    endfunction

    function longint knot(bit vdir, int unsigned idx);
      if (idx > 31) idx = 31;
      return vdir ? vknot[idx] : uknot[idx];
    endfunction

    function longint clampl(longint v, longint lim);
      return v > lim ? lim : (v < -lim ? -lim : v);
    endfunction

    function longint mul_frac(longint a, longint b);
      bit         neg;
      bit [63:0]  ua, ub;
      bit [127:0] pr;
      neg = (a < 0) != (b < 0);
      ua = a < 0 ? 64'(-a) : 64'(a);
      ub = b < 0 ? 64'(-b) : 64'(b);
      pr = {64'b0, ua} * {64'b0, ub};
      pr = pr >> 30;
      if (|pr[127:63]) return neg ? S64_MIN : S64_MAX;
      return neg ? -longint'(pr[63:0]) : longint'(pr[63:0]);
    endfunction

    function longint add_sat(longint a, longint b);
      longint s;
      s = a + b;
      if (a > 0 && b > 0 && s < 0) return S64_MAX;
      if (a < 0 && b < 0 && s >= 0) return S64_MIN;
      return s;
    endfunction

    function int unsigned span_basis(bit vdir, int unsigned p, int unsigned n, longint t,
                                     output longint nb [9], output longint db [9]);
      longint      prev [9];
      longint      lft, rgt, d0, d1;
      int unsigned span, k;
      span = p;
      for (int unsigned i = p; i < n; i++) if (knot(vdir, i) <= t) span = i;
      foreach (nb[r]) nb[r] = 0;
      nb[p] = Q30_ONE;
      prev = nb;
      for (int unsigned j = 1; j <= p; j++) begin
        if (j == p) prev = nb;
        for (int unsigned r = p - j; r <= p; r++) begin
          k = span - p + r;
          lft = 0;
          rgt = 0;
          d0 = knot(vdir, k + j) - knot(vdir, k);
          d1 = knot(vdir, k + j + 1) - knot(vdir, k + 1);
          if (d0 != 0) lft = (t - knot(vdir, k)) * nb[r] / d0;
          if (d1 != 0) rgt = (knot(vdir, k + j + 1) - t) * nb[r + 1] / d1;
          nb[r] = clampl(lft + rgt, BASIS_LIM);
        end
      end
      foreach (db[r]) db[r] = 0;
      for (int unsigned r = 0; r <= p; r++) begin
        k = span - p + r;
        lft = 0;
        rgt = 0;
        d0 = knot(vdir, k + p) - knot(vdir, k);
        d1 = knot(vdir, k + p + 1) - knot(vdir, k + 1);
        if (d0 != 0) lft = prev[r] * 65536 / d0;
        if (d1 != 0) rgt = prev[r + 1] * 65536 / d1;
        db[r] = clampl(longint'(p) * (lft - rgt), DERIV_LIM);
      end
      return span;
    endfunction

    function void note_item(surf_item_t it);
      surf_result_t res;
      longint       nu [9], du [9], nv [9], dv [9];
      longint       acc [3];
      longint       wu, wv, v;
      int unsigned  nr, nc, pu, pv, su, sv;
      bit           sat;
      res = '{ST_DONE, 0, 0, 0};
      if (it.func == FN_POINT) begin
        grid[{it.row, it.col}][0] = it.cx;
        grid[{it.row, it.col}][1] = it.cy;
        grid[{it.row, it.col}][2] = it.cz;
      end else if (it.func == FN_UKNOT) begin
        uknot[it.slot] = it.kval;
      end else if (it.func == FN_VKNOT) begin
        vknot[it.slot] = it.kval;
      end else if (it.tu < 0 || it.tu > 65536 || it.tv < 0 || it.tv > 65536) begin
        res.status = ST_RANGE;
      end else begin
        nr = ucnt < 2 ? 2 : (ucnt > 16 ? 16 : ucnt);
        nc = vcnt < 2 ? 2 : (vcnt > 16 ? 16 : vcnt);
        pu = udeg < 1 ? 1 : udeg;
        pv = vdeg < 1 ? 1 : vdeg;
        if (pu > nr - 1) pu = nr - 1;
        if (pv > nc - 1) pv = nc - 1;
        su = span_basis(1'b0, pu, nr, longint'(it.tu), nu, du);
        sv = span_basis(1'b1, pv, nc, longint'(it.tv), nv, dv);
        acc = '{0, 0, 0};
        for (int unsigned a = 0; a <= pu; a++) begin
          wu = (it.kind == KIND_DU) ? du[a] : nu[a];
          for (int unsigned b = 0; b <= pv; b++) begin
            wv = (it.kind == KIND_DV) ? dv[b] : nv[b];
            for (int c = 0; c < 3; c++)
              acc[c] = add_sat(acc[c],
                mul_frac(mul_frac(grid[(su - pu + a) * 16 + sv - pv + b][c], wu), wv));
          end
        end
        sat = 1'b0;
        for (int c = 0; c < 3; c++) begin
          v = acc[c];
          if (v > S32_MAX) begin
            v = S32_MAX;
            sat = 1'b1;
          end
          if (v < S32_MIN) begin
            v = S32_MIN;
            sat = 1'b1;
          end
          acc[c] = v;
        end
        res.x = acc[0][31:0];
        res.y = acc[1][31:0];
        res.z = acc[2][31:0];
        res.status = sat ? ST_SAT : ST_DONE;
      end
      pending.push_back(res);
    endfunction

    function void check_result(surf_result_t got);
      surf_result_t exp_r;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result: status %0d", got.status);
        return;
      end
      exp_r = pending.pop_front();
      if (got != exp_r) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp st %0d %h %h %h, got st %0d %h %h %h", exp_r.status,
                   exp_r.x, exp_r.y, exp_r.z, got.status, got.x, got.y, got.z);
      end
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         func_i = '0;
  logic [3:0]         grid_row_i = '0;
  logic [3:0]         grid_col_i = '0;
  logic [4:0]         knot_slot_i = '0;
  logic [16:0]        knot_value_i = '0;
  logic signed [31:0] coord_x_i = '0;
  logic signed [31:0] coord_y_i = '0;
  logic signed [31:0] coord_z_i = '0;
  logic signed [17:0] u_param_i = '0;
  logic signed [17:0] v_param_i = '0;
  logic [1:0]         result_kind_i = '0;
  logic               done_o;
  logic [1:0]         status_o;
  logic signed [31:0] out_x_o, out_y_o, out_z_o;
  logic               cfg_we_i = 1'b0;
  logic [1:0]         cfg_idx_i = '0;
  logic [4:0]         cfg_data_i = '0;

  surface_scoreboard sb = new();
  int                quiet_cycles = 0;
  bit                idle_on = 1'b1;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  bspline_surface_evaluator_top u_dut (.*);

  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (rst_ni && done_o) sb.check_result('{status_o, out_x_o, out_y_o, out_z_o});
    if (quiet_cycles > 100000) begin
      $display("** bspline_surface_evaluator_top: FAILED **");
      $finish;
    end
  end

  task automatic send_item(surf_item_t it);
    if (idle_on && $urandom_range(0, 99) < 24) begin
      start = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    func_i = it.func;          grid_row_i = it.row;    grid_col_i = it.col;
    knot_slot_i = it.slot;     knot_value_i = it.kval;
    coord_x_i = it.cx;         coord_y_i = it.cy;      coord_z_i = it.cz;
    u_param_i = it.tu;         v_param_i = it.tv;      result_kind_i = it.kind;
    start = 1'b1;
    do @(posedge clk_i); while (busy);
    sb.note_item(it);
    @(negedge clk_i);
  endtask

  task automatic drain();
    start = 1'b0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic set_reg(logic [1:0] idx, logic [4:0] d);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = d;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    sb.write_reg(idx, d);
  endtask

  function automatic surf_item_t blank_item(logic [1:0] f);
    surf_item_t it;
    it = '{f, 4'($urandom), 4'($urandom), 5'($urandom), 17'($urandom_range(0, 65536)),
           32'($urandom), 32'($urandom), 32'($urandom), 18'($urandom), 18'($urandom),
           2'($urandom)};
    return it;
  endfunction

  function automatic logic signed [31:0] rand_coord();
    if ($urandom_range(0, 9) < 7) return 32'($signed($urandom_range(0, 2097151)) - 1048576);
    return 32'($urandom);
  endfunction

  function automatic logic signed [17:0] rand_param();
    case ($urandom_range(0, 19))
      0: return 18'sd0;
      1: return 18'sd65536;
      2: return 18'($urandom);
      default: return 18'($urandom_range(0, 65536));
    endcase
  endfunction

  task automatic load_knots(bit vdir, int unsigned p, int unsigned n);
    surf_item_t  it;
    int unsigned k;
    bit          clamped;
    clamped = $urandom_range(0, 3) != 0;
    k = clamped ? 0 : $urandom_range(0, 20000);
    for (int unsigned i = 0; i < 32; i++) begin
      if (!(clamped && i <= p)) begin
        if (i >= n) k = 65536;
        else if ($urandom_range(0, 5) != 0) k = k + $urandom_range(0, 131072 / (n - p + 1));
      end
      if (k > 65536) k = 65536;
      it = blank_item(vdir ? FN_VKNOT : FN_UKNOT);
      it.slot = i;
      it.kval = k;
      send_item(it);
    end
  endtask

  task automatic send_eval(logic signed [17:0] tu, logic signed [17:0] tv, logic [1:0] kind);
    surf_item_t it;
    it = blank_item(FN_EVAL);
    it.tu = tu;
    it.tv = tv;
    it.kind = kind;
    send_item(it);
  endtask

  initial begin
    surf_item_t  it;
    int unsigned ud, vd, uc, vc, nev, items;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < 256; i++) begin
      it = blank_item(FN_POINT);
      {it.row, it.col} = 8'(i);
      it.cx = rand_coord(); it.cy = rand_coord(); it.cz = rand_coord();
      send_item(it);
    end
    load_knots(1'b0, 3, 4);
    load_knots(1'b1, 3, 4);

    it = blank_item(FN_POINT);
    it.row = 4'd15; it.col = 4'd15;
    it.cx = 32'sh7FFF_FFFF; it.cy = 32'sh8000_0000; it.cz = 32'sh0;
    send_item(it);
    it = blank_item(FN_POINT);
    it.row = 4'd0; it.col = 4'd0;
    it.cx = 32'sh8000_0000; it.cy = 32'sh7FFF_FFFF; it.cz = 32'shFFFF_FFFF;
    send_item(it);
    for (int k = 0; k < 4; k++) begin
      send_eval(18'sd0, 18'sd0, 2'(k));
      send_eval(18'sd65536, 18'sd65536, 2'(k));
      send_eval(18'sd32768, 18'sd12345, 2'(k));
    end
    send_eval(-18'sd1, 18'sd100, 2'd0);
    send_eval(18'sd100, 18'sd65537, 2'd0);
    send_eval(18'sh1FFFF, 18'sh20000, 2'd1);
    send_eval(18'sh20000, 18'sh1FFFF, 2'd2);

    items = 0;
    for (int ph = 0; ph < 12; ph++) begin
      drain();
      case (ph)
        0:       begin ud = 1; vd = 1; uc = 2;  vc = 2;  end
        1:       begin ud = 7; vd = 7; uc = 16; vc = 16; end
        2:       begin ud = 0; vd = 2; uc = 1;  vc = 31; end
        3:       begin ud = 7; vd = 1; uc = 8;  vc = 16; end
        default: begin
          ud = $urandom_range(0, 7); vd = $urandom_range(0, 7);
          uc = $urandom_range(0, 31); vc = $urandom_range(0, 31);
        end
      endcase
      set_reg(CFG_UDEG, 5'(ud) | (5'($urandom_range(0, 3)) << 3));
      set_reg(CFG_VDEG, 5'(vd));
      set_reg(CFG_UCNT, 5'(uc));
      set_reg(CFG_VCNT, 5'(vc));
      uc = uc < 2 ? 2 : (uc > 16 ? 16 : uc);
      vc = vc < 2 ? 2 : (vc > 16 ? 16 : vc);
      ud = ud < 1 ? 1 : (ud > uc - 1 ? uc - 1 : ud);
      vd = vd < 1 ? 1 : (vd > vc - 1 ? vc - 1 : vd);
      load_knots(1'b0, ud, uc);
      load_knots(1'b1, vd, vc);
      nev = (ud + vd > 8) ? 6 : 24;
      idle_on = (ph != 6);
      while (nev > 0) begin
        case ($urandom_range(0, 9))
          0, 1: begin
            it = blank_item(FN_POINT);
            it.cx = rand_coord(); it.cy = rand_coord(); it.cz = rand_coord();
            send_item(it);
          end
          2: begin
            if ($urandom_range(0, 3) == 0) begin
              it = blank_item($urandom_range(0, 1) ? FN_UKNOT : FN_VKNOT);
              send_item(it);
            end
          end
          default: begin
            send_eval(rand_param(), rand_param(), 2'($urandom));
            nev--;
          end
        endcase
        items++;
      end
      for (int i = 0; i < 30 && items < 1200; i++) begin
        it = blank_item(FN_POINT);
        it.cx = rand_coord(); it.cy = rand_coord(); it.cz = rand_coord();
        send_item(it);
        items++;
      end
    end

    drain();
    repeat (20) @(negedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("** bspline_surface_evaluator_top: PASSED **");
    end else begin
      $display("** bspline_surface_evaluator_top: FAILED **");
    end
    $finish;
  end

endmodule
`default_nettype wire
